### rtl/largest_empty_square_search_assert.svh
// Assertion macros for the largest empty square search checker.
// Expects clk and rst_n in the scope of use.
`ifndef LARGEST_EMPTY_SQUARE_SEARCH_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define LESQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lesq assertion failed");

// Next-cycle implication.
`define LESQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lesq assertion failed");

`endif

### rtl/lesq_pkg.sv
// Shared types and constants for the largest empty square search block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lesq_pkg;

    localparam int SIDE_W  = 7;
    localparam int COORD_W = 6;

    typedef logic [SIDE_W-1:0]  side_t;
    typedef logic [COORD_W-1:0] coord_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_GRID_ROWS = 2'd0;
    localparam cfg_idx_t CFG_GRID_COLS = 2'd1;

    localparam side_t GRID_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_GROW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic   cmd;
        coord_t cell_col;
        coord_t cell_row;
        logic   is_obstacle;
    } req_t;

    typedef struct packed {
        side_t  square_side;
        side_t  best_side;
        coord_t best_col;
        coord_t best_row;
    } rsp_t;

endpackage

`default_nettype wire

### rtl/lesq_chan_if.sv
// Valid/ready channel carrying one payload struct per request.
// Payload type comes from lesq_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface lesq_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/lesq_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lesq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

### rtl/largest_empty_square_search.sv
// Largest empty square search: top level.
// Uses lesq_pkg, lesq_chan_if and lesq_ram.
`timescale 1ns / 1ps
`default_nettype none

// The obstacle map is one RAM row word per grid row. A write request passes
// through accept, read-modify-write of the row word and result. A query
// accepted at corner (col,row) reads one row word per cycle, starting at the
// corner row, and ORs it into an accumulated obstacle word; each cycle the
// square grows by one while the accumulated word is clear over the covered
// columns and the next row and column stay inside the grid. A query ends
// when the grid edge or an obstacle stops it, or at once with side zero
// when the corner is outside the grid; the single RAM read port reads one
// row per cycle. One request is in work at a time; a finished result waits
// in the output register while the next request is taken.
module largest_empty_square_search #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lesq_chan_if.sink              req,
    lesq_chan_if.source            rsp,
    input  wire logic              cfg_we,
    input  wire lesq_pkg::cfg_idx_t cfg_index,
    input  wire lesq_pkg::side_t   cfg_data
);
    import lesq_pkg::*;

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int DIM_W  = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
    localparam int SUM_W  = (DIM_W > 8) ? DIM_W : 8;

    typedef logic [SUM_W-1:0]    sum_t;
    typedef logic [MAX_COLS-1:0] word_t;

    state_t state_reg, state_next;

    side_t  grid_rows_reg, grid_cols_reg;
    logic   cmd_reg, cmd_next;
    coord_t col_reg, col_next;
    coord_t row_reg, row_next;
    logic   obs_reg, obs_next;
    side_t  side_reg, side_next;
    word_t  bit_reg, bit_next;
    word_t  mask_reg, mask_next;
    word_t  acc_reg, acc_next;

    side_t  best_side_reg, best_side_next;
    coord_t best_col_reg, best_col_next;
    coord_t best_row_reg, best_row_next;
    side_t  out_side_reg, out_side_next;
    logic   out_valid_reg, out_valid_next;

    logic   mem_we, mem_re;
    logic [ROW_AW-1:0] mem_addr;
    word_t  mem_wdata, mem_rdata;

    sum_t   rows_use, cols_use;
    sum_t   in_row, in_col;
    sum_t   row_cur;
    logic   req_fire, out_free;
    logic   start_ok, wr_ok;
    word_t  acc_new, mask_new;
    logic   hit, edge_hit;
    side_t  side_inc;
    sum_t   row_n, col_n;

    // Register values above storage saturate.
    assign rows_use = (sum_t'(grid_rows_reg) > sum_t'(MAX_ROWS)) ? sum_t'(MAX_ROWS)
                                                                  : sum_t'(grid_rows_reg);
    assign cols_use = (sum_t'(grid_cols_reg) > sum_t'(MAX_COLS)) ? sum_t'(MAX_COLS)
                                                                  : sum_t'(grid_cols_reg);

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign in_row   = sum_t'(req.data.cell_row);
    assign in_col   = sum_t'(req.data.cell_col);
    assign row_cur  = sum_t'(row_reg);
    assign start_ok = (in_col < cols_use) && (in_row < rows_use);
    assign wr_ok    = (in_row < sum_t'(MAX_ROWS)) && (in_col < sum_t'(MAX_COLS));

    // Growth step: accumulated row words cover every row of the square.
    assign acc_new  = acc_reg | mem_rdata;
    assign mask_new = mask_reg | bit_reg;
    assign hit      = |(acc_new & mask_new);
    assign side_inc = side_reg + side_t'(1);
    assign row_n    = sum_t'(row_reg) + sum_t'(side_inc);
    assign col_n    = sum_t'(col_reg) + sum_t'(side_inc);
    assign edge_hit = (col_n >= cols_use) || (row_n >= rows_use);

    lesq_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.data.cmd == CMD_QUERY)
                    begin
                        state_next = start_ok ? ST_GROW : ST_DONE;
                    end
                    else
                    begin
                        state_next = wr_ok ? ST_WRITE : ST_DONE;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_GROW:
            begin
                if (hit || edge_hit)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = in_row[ROW_AW-1:0];
        mem_wdata      = (mem_rdata & ~bit_reg) | (obs_reg ? bit_reg : '0);
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        obs_next       = obs_reg;
        side_next      = side_reg;
        bit_next       = bit_reg;
        mask_next      = mask_reg;
        acc_next       = acc_reg;
        best_side_next = best_side_reg;
        best_col_next  = best_col_reg;
        best_row_next  = best_row_reg;
        out_side_next  = out_side_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next  = req.data.cmd;
                    col_next  = req.data.cell_col;
                    row_next  = req.data.cell_row;
                    obs_next  = req.data.is_obstacle;
                    side_next = '0;
                    bit_next  = word_t'(1) << req.data.cell_col;
                    mask_next = '0;
                    acc_next  = '0;
                    mem_re    = (req.data.cmd == CMD_QUERY) ? start_ok : wr_ok;
                end
            end
            ST_WRITE:
            begin
                mem_we   = 1'b1;
                mem_addr = row_cur[ROW_AW-1:0];
            end
            ST_GROW:
            begin
                if (!hit)
                begin
                    side_next = side_inc;
                    acc_next  = acc_new;
                    mask_next = mask_new;
                    bit_next  = bit_reg << 1;
                    if (!edge_hit)
                    begin
                        mem_re   = 1'b1;
                        mem_addr = row_n[ROW_AW-1:0];
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_side_next  = side_reg;
                    if ((cmd_reg == CMD_QUERY) && (side_reg > best_side_reg))
                    begin
                        best_side_next = side_reg;
                        best_col_next  = col_reg;
                        best_row_next  = row_reg;
                    end
                end
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grid_rows_reg <= GRID_RESET;
            grid_cols_reg <= GRID_RESET;
            best_side_reg <= '0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            out_side_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            best_side_reg <= best_side_next;
            best_col_reg  <= best_col_next;
            best_row_reg  <= best_row_next;
            out_side_reg  <= out_side_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_GRID_ROWS))
            begin
                grid_rows_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_GRID_COLS))
            begin
                grid_cols_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        obs_reg  <= obs_next;
        side_reg <= side_next;
        bit_reg  <= bit_next;
        mask_reg <= mask_next;
        acc_reg  <= acc_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.data.square_side = out_side_reg;
    assign rsp.data.best_side   = best_side_reg;
    assign rsp.data.best_col    = best_col_reg;
    assign rsp.data.best_row    = best_row_reg;
endmodule

`default_nettype wire

### rtl/lesq_checker.sv
// Port-level assertions for the largest empty square search, bound to the top.
// Uses lesq_pkg and the macros in largest_empty_square_search_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "largest_empty_square_search_assert.svh"

module lesq_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire lesq_pkg::side_t  square_side,
    input wire lesq_pkg::side_t  best_side,
    input wire lesq_pkg::coord_t best_col,
    input wire lesq_pkg::coord_t best_row
);
    import lesq_pkg::*;

    // A held result keeps its payload.
    `LESQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(square_side) && $stable(best_side)
        && $stable(best_col) && $stable(best_row))

    // The best is at least the side just reported.
    `LESQ_ASSERT_IMP(a_side_le_best, rsp_valid, square_side <= best_side)

    // The best never shrinks.
    `LESQ_ASSERT_NXT(a_best_mono, 1'b1, best_side >= $past(best_side))

    // One request in work at a time.
    `LESQ_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)
endmodule

bind largest_empty_square_search lesq_checker u_lesq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .square_side (rsp.data.square_side),
    .best_side   (rsp.data.best_side),
    .best_col    (rsp.data.best_col),
    .best_row    (rsp.data.best_row)
);

`default_nettype wire

### dv/largest_empty_square_search_test.sv
`timescale 1ns / 1ps
// Self-checking bench for largest_empty_square_search: cell writes and square
// queries over several grid geometries, checked against a square-growth predictor.
// Depends on lesq_pkg, lesq_chan_if and the largest_empty_square_search RTL.

module largest_empty_square_search_test;
    import lesq_pkg::*;

    localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
    localparam cfg_idx_t CFG_SPARE_3 = 2'd3;
    localparam int STORE_ROWS      = 64;
    localparam int STORE_COLS      = 64;
    localparam int REGION          = 16;
    localparam int FAR_LO          = 56;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int NUM_PHASES      = 10;
    localparam int PHASE_ITEMS     = 100;
    localparam int HOLD_PHASE      = 4;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    side_t    cfg_data;

    lesq_chan_if #(.payload_t(req_t)) req_if ();
    lesq_chan_if #(.payload_t(rsp_t)) rsp_if ();

    largest_empty_square_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // grid geometry per random phase, kept inside the low region; 0 picks a random size
    int phase_rows [NUM_PHASES] = '{2, 8, 1, 16, 16, 0, 12, 16, 0, 16};
    int phase_cols [NUM_PHASES] = '{3, 8, 16, 1, 16, 0, 9, 16, 0, 16};

    // predictor state
    bit [STORE_COLS-1:0] obstacle_rows [STORE_ROWS];
    side_t  grid_rows_q = GRID_RESET;
    side_t  grid_cols_q = GRID_RESET;
    side_t  best_side_q = '0;
    coord_t best_col_q  = '0;
    coord_t best_row_q  = '0;

    req_t   cell_requests [$];
    rsp_t   predicted_squares [$];

    int     mismatch_count = 0;
    bit     calm           = 1'b0;
    bit     hold_request   = 1'b0;
    logic   hold_rsp       = 1'b0;
    int     send_gap       = 0;
    int     recv_stall     = 0;
    logic   offer_next;
    logic   popped;
    req_t   next_req;
    rsp_t   want;

    function automatic bit cell_free(int col, int row);
        int rows_used;
        int cols_used;
        rows_used = (grid_rows_q > STORE_ROWS) ? STORE_ROWS : grid_rows_q;
        cols_used = (grid_cols_q > STORE_COLS) ? STORE_COLS : grid_cols_q;
        if (col >= cols_used || row >= rows_used)
            return 1'b0;
        return !obstacle_rows[row][col];
    endfunction

    // new bottom row and new right column of a square of side+1
    function automatic bit square_extends(int col, int row, int side);
        for (int i = 0; i <= side; i++)
            if (!cell_free(col + i, row + side) || !cell_free(col + side, row + i))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic rsp_t predict_square_result(req_t r);
        int   side;
        rsp_t res;
        side = 0;
        if (r.cmd == CMD_WRITE)
            obstacle_rows[r.cell_row][r.cell_col] = r.is_obstacle;
        else
        begin
            while (side < 128 && square_extends(r.cell_col, r.cell_row, side))
                side++;
            if (side > best_side_q)
            begin
                best_side_q = side_t'(side);
                best_col_q  = r.cell_col;
                best_row_q  = r.cell_row;
            end
        end
        res.square_side = side_t'(side);
        res.best_side   = best_side_q;
        res.best_col    = best_col_q;
        res.best_row    = best_row_q;
        return res;
    endfunction

    task automatic report_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic queue_cell(coord_t col, coord_t row, logic obstacle);
        req_t r;
        r.cmd         = CMD_WRITE;
        r.cell_col    = col;
        r.cell_row    = row;
        r.is_obstacle = obstacle;
        cell_requests.push_back(r);
    endtask

    task automatic queue_query(coord_t col, coord_t row);
        req_t r;
        r.cmd         = CMD_QUERY;
        r.cell_col    = col;
        r.cell_row    = row;
        r.is_obstacle = logic'($urandom_range(0, 1));
        cell_requests.push_back(r);
    endtask

    // block is idle once nothing is queued, offered or owed
    task automatic wait_idle();
        @(negedge clk);
        while (cell_requests.size() != 0 || req_if.valid || predicted_squares.size() != 0)
            @(negedge clk);
    endtask

    // only called while idle
    task automatic write_register(cfg_idx_t idx, side_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_GRID_ROWS)
            grid_rows_q = value;
        else if (idx == CFG_GRID_COLS)
            grid_cols_q = value;
        @(negedge clk);
    endtask

    task automatic set_grid(int rows, int cols);
        write_register(CFG_GRID_ROWS, side_t'(rows));
        write_register(CFG_GRID_COLS, side_t'(cols));
    endtask

    // corners and cells mostly inside the grid in use, a few anywhere in storage
    task automatic queue_random_items(int count);
        int     span_r;
        int     span_c;
        coord_t col;
        coord_t row;
        span_r = (grid_rows_q == 0 || grid_rows_q > STORE_ROWS) ? STORE_ROWS : grid_rows_q;
        span_c = (grid_cols_q == 0 || grid_cols_q > STORE_COLS) ? STORE_COLS : grid_cols_q;
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                col = coord_t'($urandom_range(0, STORE_COLS - 1));
                row = coord_t'($urandom_range(0, STORE_ROWS - 1));
            end
            else
            begin
                col = coord_t'($urandom_range(0, span_c - 1));
                row = coord_t'($urandom_range(0, span_r - 1));
            end
            if ($urandom_range(0, 99) < 55)
                queue_query(col, row);
            else
                queue_cell(col, row, $urandom_range(0, 3) == 0);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            offer_next = req_if.valid;
            popped     = 1'b0;
            if (req_if.valid && req_if.ready)
            begin
                predicted_squares.push_back(predict_square_result(req_if.data));
                offer_next = 1'b0;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 10);
            end
            if (!offer_next)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (cell_requests.size() != 0)
                begin
                    next_req   = cell_requests.pop_front();
                    offer_next = 1'b1;
                    popped     = 1'b1;
                end
            end
            req_if.valid <= offer_next;
            if (popped)
                req_if.data <= next_req;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (predicted_squares.size() == 0)
                    report_error($sformatf("result with no request pending: side %0d best %0d",
                                           rsp_if.data.square_side, rsp_if.data.best_side));
                else
                begin
                    want = predicted_squares.pop_front();
                    if (rsp_if.data.square_side !== want.square_side ||
                        rsp_if.data.best_side   !== want.best_side   ||
                        rsp_if.data.best_col    !== want.best_col    ||
                        rsp_if.data.best_row    !== want.best_row)
                        report_error($sformatf(
                            "mismatch: side %0d best %0d at (%0d,%0d), expected %0d best %0d at (%0d,%0d)",
                            rsp_if.data.square_side, rsp_if.data.best_side,
                            rsp_if.data.best_col, rsp_if.data.best_row,
                            want.square_side, want.best_side, want.best_col, want.best_row));
                end
            end
            if (recv_stall > 0)
                recv_stall--;
            else if (!calm && $urandom_range(0, 7) == 0)
                recv_stall = $urandom_range(1, 10);
            rsp_if.ready <= (recv_stall == 0) && !hold_rsp;
        end
    end

    // long receiver hold-off so the block backs up into the request side
    initial
    begin : rsp_hold_window
        wait (hold_request);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin : stimulus
        int rows_pick;
        int cols_pick;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_GRID_ROWS;
        cfg_data     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // queries only reach the low region, the far corner block and the
        // far edge strips, so those cells are written once up front
        for (int r = 0; r < REGION; r++)
            for (int c = 0; c < REGION; c++)
                queue_cell(coord_t'(c), coord_t'(r), $urandom_range(0, 19) == 0);
        for (int r = FAR_LO; r < STORE_ROWS; r++)
            for (int c = FAR_LO; c < STORE_COLS; c++)
                queue_cell(coord_t'(c), coord_t'(r), $urandom_range(0, 19) == 0);
        for (int r = FAR_LO; r < STORE_ROWS; r++)
            queue_cell(6'd0, coord_t'(r), $urandom_range(0, 19) == 0);
        for (int c = FAR_LO; c < STORE_COLS; c++)
            queue_cell(coord_t'(c), 6'd0, $urandom_range(0, 19) == 0);
        wait_idle();

        // reset geometry, far corners and edges
        queue_query(6'd63, 6'd63);
        queue_query(6'd0, 6'd63);
        queue_query(6'd63, 6'd0);
        queue_query(6'd62, 6'd62);
        queue_cell(6'd63, 6'd63, 1'b1);
        queue_query(6'd63, 6'd63);
        queue_cell(6'd63, 6'd63, 1'b0);
        queue_query(6'd63, 6'd63);
        wait_idle();

        // empty grid: every query gives zero
        write_register(CFG_GRID_ROWS, 7'd0);
        queue_query(6'd0, 6'd0);
        queue_query(6'd17, 6'd3);
        wait_idle();

        // oversized registers clamp to storage
        set_grid(127, 100);
        queue_query(6'd63, 6'd63);
        queue_query(6'd58, 6'd60);
        wait_idle();

        // writes to unused indexes leave the geometry alone
        write_register(CFG_SPARE_2, 7'd5);
        write_register(CFG_SPARE_3, 7'd9);
        queue_query(6'd62, 6'd62);
        wait_idle();

        // single cell grid, corners just outside
        set_grid(1, 1);
        queue_cell(6'd0, 6'd0, 1'b0);
        queue_query(6'd0, 6'd0);
        queue_query(6'd1, 6'd0);
        queue_query(6'd0, 6'd1);
        wait_idle();

        set_grid(64, 1);
        queue_query(6'd0, 6'd60);
        queue_query(6'd0, 6'd0);
        wait_idle();
        set_grid(1, 64);
        queue_query(6'd60, 6'd0);
        wait_idle();

        // random phases, each with its own grid geometry
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            rows_pick = (phase_rows[p] == 0) ? $urandom_range(1, REGION) : phase_rows[p];
            cols_pick = (phase_cols[p] == 0) ? $urandom_range(1, REGION) : phase_cols[p];
            set_grid(rows_pick, cols_pick);
            if (p == NUM_PHASES - 1)
                calm = 1'b1;
            if (p == HOLD_PHASE)
                hold_request = 1'b1;
            queue_random_items(PHASE_ITEMS);
            wait_idle();
        end

        // clear the low region, then grow the full grid square
        set_grid(REGION, REGION);
        for (int r = 0; r < REGION; r++)
            for (int c = 0; c < REGION; c++)
                if (obstacle_rows[r][c])
                    queue_cell(coord_t'(c), coord_t'(r), 1'b0);
        queue_query(6'd1, 6'd1);
        queue_query(6'd0, 6'd0);
        queue_query(6'd0, 6'd0);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && predicted_squares.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
